// File: hdl/pws_pkg.sv
// Shared widths, codes, command struct and arctangent table for the wheel speed block.
`default_nettype none

package pws_pkg;

  localparam int POS_W        = 24;              // path coordinate width
  localparam int DIFF_W       = POS_W + 1;       // step between two points
  localparam int ANG_W        = 16;              // binary angle width
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_SHIFT = 24;              // prescale of the step before rotation
  localparam int CRD_W        = DIFF_W + CORDIC_SHIFT + 3;
  localparam int ZACC_W       = 32;              // angle accumulator
  localparam int RAD_W        = 2 * POS_W + 2;   // sum of squares, even width
  localparam int ROOT_W       = RAD_W / 2;
  localparam int SQRT_STEPS   = RAD_W / 2;
  localparam int STEP_W       = 5;
  localparam int WB_W         = 12;
  localparam int RATE_W       = 14;
  localparam int VEL_W        = ROOT_W + RATE_W;
  localparam int P_W          = WB_W + ANG_W + RATE_W;
  localparam int PH_W         = P_W - 32;
  localparam int TERM_W       = 33;
  localparam int SUM_W        = VEL_W + 2;
  localparam int OUT_W        = 32;
  localparam int MUL_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = RATE_W;

  localparam logic [WB_W-1:0]   WB_RESET   = 12'd100;
  localparam logic [RATE_W-1:0] RATE_RESET = 14'd50;
  localparam logic [31:0]       PI_Q30     = 32'd3373259426;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_AX   = 3'd1,
    MUL_AY   = 3'd2,
    MUL_VEL  = 3'd3,
    MUL_WB   = 3'd4,
    MUL_RATE = 3'd5,
    MUL_PL   = 3'd6,
    MUL_PH   = 3'd7
  } mul_op_t;

  typedef struct packed {
    logic              load;
    logic              cordic_init;
    logic              sq_save;
    logic              rad_load;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              head_load;
    logic              v_load;
    logic              ph_load;
    logic              lo_load;
    logic              term_load;
    logic              out_load;
    mul_op_t           mul_op;
  } cmd_t;

  function automatic logic [ZACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [ZACC_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pws_ctrl.sv
// Sequencer for the wheel speed datapath: one item at a time through squares, roots and products.
`default_nettype none

module pws_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          out_stall,
  output logic               out_valid,
  output pws_pkg::cmd_t      cmd
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0_0000_0000_0001,
    ST_SQX  = 13'b0_0000_0000_0010,
    ST_SQY  = 13'b0_0000_0000_0100,
    ST_ADD  = 13'b0_0000_0000_1000,
    ST_ITER = 13'b0_0000_0001_0000,
    ST_HEAD = 13'b0_0000_0010_0000,
    ST_VEL  = 13'b0_0000_0100_0000,
    ST_WB   = 13'b0_0000_1000_0000,
    ST_RATE = 13'b0_0001_0000_0000,
    ST_PLO  = 13'b0_0010_0000_0000,
    ST_PHI  = 13'b0_0100_0000_0000,
    ST_SUM  = 13'b0_1000_0000_0000,
    ST_DONE = 13'b1_0000_0000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pws_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_op    = pws_pkg::MUL_NONE;
    cmd.step      = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.mul_op      = pws_pkg::MUL_AX;
        cmd.cordic_init = 1'b1;
        state_nxt       = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_op  = pws_pkg::MUL_AY;
        cmd.sq_save = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        cmd.rad_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == pws_pkg::STEP_W'(pws_pkg::SQRT_STEPS - 1)) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = ST_VEL;
      end
      ST_VEL: begin
        cmd.mul_op = pws_pkg::MUL_VEL;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        cmd.v_load = 1'b1;
        cmd.mul_op = pws_pkg::MUL_WB;
        state_nxt  = ST_RATE;
      end
      ST_RATE: begin
        cmd.mul_op = pws_pkg::MUL_RATE;
        state_nxt  = ST_PLO;
      end
      ST_PLO: begin
        cmd.ph_load = 1'b1;
        cmd.mul_op  = pws_pkg::MUL_PL;
        state_nxt   = ST_PHI;
      end
      ST_PHI: begin
        cmd.lo_load = 1'b1;
        cmd.mul_op  = pws_pkg::MUL_PH;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.term_load = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pws_dp.sv
// Datapath: step, square root, CORDIC heading, shared multiplier and saturating wheel sums.
`default_nettype none

module pws_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pws_pkg::cmd_t                       cmd,
  input  wire logic                                cfg_wr_en,
  input  wire logic [pws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic signed [pws_pkg::POS_W-1:0]    in_x_position,
  input  wire logic signed [pws_pkg::POS_W-1:0]    in_y_position,
  output logic signed [pws_pkg::OUT_W-1:0]         out_right_speed,
  output logic signed [pws_pkg::OUT_W-1:0]         out_left_speed,
  output logic [pws_pkg::ANG_W-1:0]                out_heading
);

  localparam int CRD_W  = pws_pkg::CRD_W;
  localparam int RAD_W  = pws_pkg::RAD_W;
  localparam int SUM_W  = pws_pkg::SUM_W;
  localparam int OUT_W  = pws_pkg::OUT_W;
  localparam int MUL_W  = pws_pkg::MUL_W;

  // configuration and architectural state
  logic [pws_pkg::WB_W-1:0]          wb_r;
  logic [pws_pkg::RATE_W-1:0]        rate_r;
  logic [pws_pkg::POS_W-1:0]         last_x_r, last_y_r;
  logic [pws_pkg::ANG_W-1:0]         last_head_r;

  // working registers
  logic signed [pws_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic                              zero_r;
  logic [2*MUL_W-1:0]                prod_r;
  logic [RAD_W-1:0]                  sq_r;
  logic [RAD_W-1:0]                  rem_r, root_r, bit_r;
  logic signed [CRD_W-1:0]           cx_r, cy_r;
  logic [pws_pkg::ZACC_W-1:0]        cz_r;
  logic [pws_pkg::ANG_W-1:0]         head_r;
  logic [pws_pkg::VEL_W-1:0]         v_r;
  logic [pws_pkg::PH_W-1:0]          ph_r;
  logic [31:0]                       lo_r;
  logic [pws_pkg::TERM_W-1:0]        term_r;
  logic signed [OUT_W-1:0]           right_r, left_r;
  logic [pws_pkg::ANG_W-1:0]         heading_r;

  // combinational
  logic signed [pws_pkg::DIFF_W-1:0] dx_nxt, dy_nxt;
  logic [pws_pkg::DIFF_W-1:0]        ax, ay;
  logic [MUL_W-1:0]                  mul_a, mul_b;
  logic signed [CRD_W-1:0]           x0, y0, xs, ys;
  logic [pws_pkg::STEP_W-1:0]        sh;
  logic                              y_pos;
  logic [RAD_W:0]                    trial;
  logic [pws_pkg::ZACC_W-1:0]        z_round;
  logic [pws_pkg::ANG_W-1:0]         dd, ad;
  logic                              d_neg;
  logic [pws_pkg::PH_W+33:0]         hi_sum;
  logic signed [SUM_W-1:0]           v_ext, t_ext, right_sum, left_sum;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] s);
    logic signed [OUT_W-1:0] r;
    if (s[SUM_W-1:OUT_W-1] == '0 || s[SUM_W-1:OUT_W-1] == '1) begin
      r = s[OUT_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign dx_nxt = {in_x_position[pws_pkg::POS_W-1], in_x_position}
                - {last_x_r[pws_pkg::POS_W-1], last_x_r};
  assign dy_nxt = {in_y_position[pws_pkg::POS_W-1], in_y_position}
                - {last_y_r[pws_pkg::POS_W-1], last_y_r};

  assign ax = dx_r[pws_pkg::DIFF_W-1] ? -dx_r : dx_r;
  assign ay = dy_r[pws_pkg::DIFF_W-1] ? -dy_r : dy_r;

  // heading change wrapped to a half turn
  assign dd    = head_r - last_head_r;
  assign d_neg = dd[pws_pkg::ANG_W-1];
  assign ad    = d_neg ? (~dd + 1'b1) : dd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      pws_pkg::MUL_AX: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(ax);
      end
      pws_pkg::MUL_AY: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(ay);
      end
      pws_pkg::MUL_VEL: begin
        mul_a = MUL_W'(root_r[pws_pkg::ROOT_W-1:0]);
        mul_b = MUL_W'(rate_r);
      end
      pws_pkg::MUL_WB: begin
        mul_a = MUL_W'(ad);
        mul_b = MUL_W'(wb_r);
      end
      pws_pkg::MUL_RATE: begin
        mul_a = MUL_W'(prod_r[pws_pkg::WB_W+pws_pkg::ANG_W-1:0]);
        mul_b = MUL_W'(rate_r);
      end
      pws_pkg::MUL_PL: begin
        mul_a = prod_r[31:0];
        mul_b = pws_pkg::PI_Q30;
      end
      pws_pkg::MUL_PH: begin
        mul_a = MUL_W'(ph_r);
        mul_b = pws_pkg::PI_Q30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // CORDIC vectoring: left half plane is turned by a half turn first
  assign x0    = CRD_W'(dx_r) <<< pws_pkg::CORDIC_SHIFT;
  assign y0    = CRD_W'(dy_r) <<< pws_pkg::CORDIC_SHIFT;
  assign sh    = cmd.step;
  assign xs    = cx_r >>> sh;
  assign ys    = cy_r >>> sh;
  assign y_pos = !cy_r[CRD_W-1] && (cy_r != '0);

  assign trial   = {1'b0, root_r} + {1'b0, bit_r};
  assign z_round = cz_r + (pws_pkg::ZACC_W'(1) << (pws_pkg::ZACC_W - pws_pkg::ANG_W - 1));
  assign hi_sum  = (pws_pkg::PH_W+34)'(prod_r[pws_pkg::PH_W+31:0]) + (pws_pkg::PH_W+34)'(lo_r);

  assign v_ext     = SUM_W'(v_r);
  assign t_ext     = d_neg ? -SUM_W'(term_r) : SUM_W'(term_r);
  assign right_sum = v_ext + t_ext;
  assign left_sum  = v_ext - t_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r        <= pws_pkg::WB_RESET;
      rate_r      <= pws_pkg::RATE_RESET;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_head_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pws_pkg::REG_WHEEL_BASE:  wb_r   <= cfg_wdata[pws_pkg::WB_W-1:0];
          pws_pkg::REG_SAMPLE_RATE: rate_r <= cfg_wdata[pws_pkg::RATE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        last_x_r <= in_x_position;
        last_y_r <= in_y_position;
      end
      if (cmd.out_load) begin
        last_head_r <= head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      zero_r <= (dx_nxt == '0) && (dy_nxt == '0);
    end
    if (cmd.mul_op != pws_pkg::MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.sq_save) begin
      sq_r <= prod_r[RAD_W-1:0];
    end
    if (cmd.rad_load) begin
      rem_r  <= sq_r + prod_r[RAD_W-1:0];
      root_r <= '0;
      bit_r  <= RAD_W'(1) << (RAD_W - 2);
    end else if (cmd.iter) begin
      // one root bit a step
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - trial[RAD_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cordic_init) begin
      if (dx_r[pws_pkg::DIFF_W-1]) begin
        cx_r <= -x0;
        cy_r <= -y0;
        cz_r <= pws_pkg::ZACC_W'(1) << (pws_pkg::ZACC_W - 1);
      end else begin
        cx_r <= x0;
        cy_r <= y0;
        cz_r <= '0;
      end
    end else if (cmd.iter && (cmd.step < pws_pkg::STEP_W'(pws_pkg::CORDIC_STEPS))) begin
      if (y_pos) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + pws_pkg::atan_entry(cmd.step);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - pws_pkg::atan_entry(cmd.step);
      end
    end
    if (cmd.head_load) begin
      head_r <= zero_r ? '0 : z_round[pws_pkg::ZACC_W-1 -: pws_pkg::ANG_W];
    end
    if (cmd.v_load) begin
      v_r <= prod_r[pws_pkg::VEL_W-1:0];
    end
    if (cmd.ph_load) begin
      ph_r <= prod_r[pws_pkg::P_W-1:32];
    end
    if (cmd.lo_load) begin
      lo_r <= prod_r[63:32];
    end
    if (cmd.term_load) begin
      // drop the angle scale: pi in Q30 over a 2^ANG_W turn, times 16
      term_r <= hi_sum[pws_pkg::ANG_W-6 +: pws_pkg::TERM_W];
    end
    if (cmd.out_load) begin
      right_r   <= sat(right_sum);
      left_r    <= sat(left_sum);
      heading_r <= head_r;
    end
  end

  assign out_right_speed = right_r;
  assign out_left_speed  = left_r;
  assign out_heading     = heading_r;

endmodule

`default_nettype wire

// File: hdl/path_to_wheel_speeds_unit.sv
// Top level of the path point to wheel speed converter.
// One item at a time; the pace is set by the 25-step square root, which also
// carries the 16 CORDIC steps, and the shared 32x32 multiplier used seven times.
// The output register lets a new item enter while the previous result is not yet taken.
// Reset (synchronous, rst_n low): previous point and heading cleared, wheel_base 100,
// sample_rate_hz 50, no result pending.
`default_nettype none

module path_to_wheel_speeds_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [pws_pkg::POS_W-1:0]    in_x_position,
  input  wire logic signed [pws_pkg::POS_W-1:0]    in_y_position,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pws_pkg::OUT_W-1:0]         out_right_speed,
  output logic signed [pws_pkg::OUT_W-1:0]         out_left_speed,
  output logic [pws_pkg::ANG_W-1:0]                out_heading,
  input  wire logic                                cfg_wr_en,
  input  wire logic [pws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  pws_pkg::cmd_t cmd;

  pws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pws_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .out_right_speed (out_right_speed),
    .out_left_speed  (out_left_speed),
    .out_heading     (out_heading)
  );

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting an item");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // finishing an item always leaves its result waiting
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("item finished without a result");

endmodule

`default_nettype wire
